/* hw/rtl/phht_pkg.sv */
// ----------------------------------------------------------------------------
// phht_pkg
// Shared widths, register indexes, event codes and the structs that pass
// between the blocks of the proximity hold timer.
// ----------------------------------------------------------------------------
package phht_pkg;

   // Field widths
   localparam int ECHO_W  = 16;
   localparam int TIME_W  = 32;
   localparam int DIST_W  = 19;
   localparam int EVENT_W = 2;

   // Register widths
   localparam int SCALE_W = 12;
   localparam int ALPHA_W = 8;
   localparam int THR_W   = 10;
   localparam int HOLD_W  = 16;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_SCALE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTER       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EXIT        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD        = 3'd4;

   // Register reset values
   localparam logic [SCALE_W-1:0] SCALE_RST = 12'd1124;
   localparam logic [ALPHA_W-1:0] ALPHA_RST = 8'd51;
   localparam logic [THR_W-1:0]   ENTER_RST = 10'd15;
   localparam logic [THR_W-1:0]   EXIT_RST  = 10'd20;
   localparam logic [HOLD_W-1:0]  HOLD_RST  = 16'd6000;

   // Largest distance in cm Q8
   localparam logic [DIST_W-1:0] DIST_MAX = 19'd524287;

   // Event codes
   localparam logic [EVENT_W-1:0] EV_NONE    = 2'd0;
   localparam logic [EVENT_W-1:0] EV_ENTER   = 2'd1;
   localparam logic [EVENT_W-1:0] EV_RETURN  = 2'd2;
   localparam logic [EVENT_W-1:0] EV_EXPIRED = 2'd3;

   typedef struct packed {
      logic [SCALE_W-1:0] speed_scale_q16;
      logic [ALPHA_W-1:0] alpha_q8;
      logic [THR_W-1:0]   enter_cm;
      logic [THR_W-1:0]   exit_cm;
      logic [HOLD_W-1:0]  hold_ms;
   } cfg_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic scale;
      logic mix_a;
      logic mix_b;
      logic commit;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic finished;
   } stat_type;

   typedef struct packed {
      logic [DIST_W-1:0]  smoothed_cm_q8;
      logic               near_mode;
      logic [EVENT_W-1:0] event_res;
      logic               finished;
   } res_type;

endpackage

/* hw/rtl/phht_channels.sv */
// ----------------------------------------------------------------------------
// phht channels
// Valid/ready channels for the echo items and the result items.
// ----------------------------------------------------------------------------
interface phht_req_if import phht_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [ECHO_W-1:0] echo_us;
   logic [TIME_W-1:0] now_ms;

   modport source (output valid, echo_us, now_ms, input ready);
   modport sink   (input valid, echo_us, now_ms, output ready);
endinterface

interface phht_rsp_if import phht_pkg::*; ;
   logic               valid;
   logic               ready;
   logic [DIST_W-1:0]  smoothed_cm_q8;
   logic               near_mode;
   logic [EVENT_W-1:0] event_res;
   logic               finished;

   modport source (output valid, smoothed_cm_q8, near_mode, event_res, finished,
                   input ready);
   modport sink   (input valid, smoothed_cm_q8, near_mode, event_res, finished,
                   output ready);
endinterface

/* hw/rtl/phht_csr.sv */
// ----------------------------------------------------------------------------
// phht_csr
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module phht_csr import phht_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write; unknown indexes leave everything alone
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SPEED_SCALE: cfg_in.speed_scale_q16 = csr_wdata[SCALE_W-1:0];
            CSR_ALPHA:       cfg_in.alpha_q8        = csr_wdata[ALPHA_W-1:0];
            CSR_ENTER:       cfg_in.enter_cm        = csr_wdata[THR_W-1:0];
            CSR_EXIT:        cfg_in.exit_cm         = csr_wdata[THR_W-1:0];
            CSR_HOLD:        cfg_in.hold_ms         = csr_wdata[HOLD_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_scale_q16 <= SCALE_RST;
         cfg_ff.alpha_q8        <= ALPHA_RST;
         cfg_ff.enter_cm        <= ENTER_RST;
         cfg_ff.exit_cm         <= EXIT_RST;
         cfg_ff.hold_ms         <= HOLD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hw/rtl/phht_ctrl.sv */
// ----------------------------------------------------------------------------
// phht_ctrl
// Sequencer: steps one item through scale, two mix steps and the decision
// (straight to the decision once done); owns the result register valid flag.
// ----------------------------------------------------------------------------
module phht_ctrl import phht_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCALE  = 3'd1;
   localparam logic [2:0] ST_MIX_A  = 3'd2;
   localparam logic [2:0] ST_MIX_B  = 3'd3;
   localparam logic [2:0] ST_DECIDE = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               // once finished, items skip the arithmetic
               state_in = stat.finished ? ST_DECIDE : ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_MIX_A;
         end
         ST_MIX_A: begin
            cmd.mix_a = 1'b1;
            state_in  = ST_MIX_B;
         end
         ST_MIX_B: begin
            cmd.mix_b = 1'b1;
            state_in  = ST_DECIDE;
         end
         ST_DECIDE: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Result register valid flag
   assign rsp_valid_in = cmd.commit | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* hw/rtl/phht_dpath.sv */
// ----------------------------------------------------------------------------
// phht_dpath
// Distance scaling, exponential average, hysteresis decision, hold timer and
// the result register.
// ----------------------------------------------------------------------------
module phht_dpath import phht_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  cmd_type           cmd,
   input  logic [ECHO_W-1:0] echo_us,
   input  logic [TIME_W-1:0] now_ms,
   output stat_type          stat,
   output res_type           res
);

   localparam int SCALE_P_W = ECHO_W + SCALE_W;     // 28
   localparam int MIX_P_W   = DIST_W + ALPHA_W;     // 27

   // Item registers
   logic [ECHO_W-1:0]  echo_ff;
   logic [TIME_W-1:0]  now_ff;
   logic [DIST_W-1:0]  sample_ff;
   logic [DIST_W-1:0]  sample_in;
   logic [MIX_P_W-1:0] prod_ff;
   logic [MIX_P_W-1:0] prod_in;
   logic [DIST_W-1:0]  avg_ff;
   logic [DIST_W-1:0]  avg_in;

   // Persistent state
   logic [DIST_W-1:0]  smooth_ff;
   logic               near_ff;
   logic               near_in;
   logic [TIME_W-1:0]  start_ff;
   logic [TIME_W-1:0]  start_in;
   logic               fin_ff;
   logic               expire;

   res_type            res_ff;
   res_type            res_in;

   logic [SCALE_P_W-1:0] scale_prod;
   logic [SCALE_W+7:0]   scale_shift;
   logic [ALPHA_W:0]     beta;
   logic [MIX_P_W-1:0]   beta_prod;
   logic [MIX_P_W-1:0]   mix_acc;
   logic [DIST_W-1:0]    enter_lim;
   logic [DIST_W-1:0]    exit_lim;
   logic [TIME_W-1:0]    elapsed;
   logic [EVENT_W-1:0]   event_code;

   // Scale echo width to cm Q8, round half up, saturate
   always_comb begin
      scale_prod  = {{SCALE_W{1'b0}}, echo_ff} * {{ECHO_W{1'b0}}, cfg.speed_scale_q16}
                  + SCALE_P_W'(128);
      scale_shift = scale_prod[SCALE_P_W-1:8];
      if (scale_shift > {1'b0, DIST_MAX}) begin
         sample_in = DIST_MAX;
      end else begin
         sample_in = scale_shift[DIST_W-1:0];
      end
   end

   // Weighted new sample
   assign prod_in = {{DIST_W{1'b0}}, cfg.alpha_q8} * {{ALPHA_W{1'b0}}, sample_ff};

   // Weighted stored average, sum and round; a zero average takes the sample
   always_comb begin
      beta      = 9'd256 - {1'b0, cfg.alpha_q8};
      beta_prod = {{(MIX_P_W-ALPHA_W-1){1'b0}}, beta} * {{ALPHA_W{1'b0}}, smooth_ff};
      mix_acc   = prod_ff + beta_prod + MIX_P_W'(128);
      if (smooth_ff == '0) begin
         avg_in = sample_ff;
      end else begin
         avg_in = mix_acc[MIX_P_W-1:8];
      end
   end

   // Hysteresis and hold timer
   always_comb begin
      enter_lim  = {1'b0, cfg.enter_cm, 8'b0};
      exit_lim   = {1'b0, cfg.exit_cm, 8'b0};
      near_in    = near_ff;
      start_in   = start_ff;
      event_code = EV_NONE;
      if (avg_ff <= enter_lim) begin
         if (!near_ff) begin
            near_in    = 1'b1;
            start_in   = now_ff;
            event_code = EV_ENTER;
         end
      end else if (avg_ff >= exit_lim) begin
         if (near_ff) begin
            near_in    = 1'b0;
            event_code = EV_RETURN;
         end
      end
      elapsed = now_ff - start_in;
      expire  = near_in && (elapsed >= {{(TIME_W-HOLD_W){1'b0}}, cfg.hold_ms});
      if (expire) begin
         event_code = EV_EXPIRED;
      end
   end

   // Result fields; after finishing, repeat the stored state
   always_comb begin
      if (fin_ff) begin
         res_in.smoothed_cm_q8 = smooth_ff;
         res_in.near_mode      = near_ff;
         res_in.event_res      = EV_NONE;
         res_in.finished       = 1'b1;
      end else begin
         res_in.smoothed_cm_q8 = avg_ff;
         res_in.near_mode      = near_in;
         res_in.event_res      = event_code;
         res_in.finished       = expire;
      end
   end

   // Item and result registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         echo_ff <= echo_us;
         now_ff  <= now_ms;
      end
      if (cmd.scale) begin
         sample_ff <= sample_in;
      end
      if (cmd.mix_a) begin
         prod_ff <= prod_in;
      end
      if (cmd.mix_b) begin
         avg_ff <= avg_in;
      end
      if (cmd.commit) begin
         res_ff <= res_in;
      end
   end

   // Persistent state, advanced on commit until done
   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_ff <= '0;
         near_ff   <= 1'b0;
         start_ff  <= '0;
         fin_ff    <= 1'b0;
      end else if (cmd.commit && !fin_ff) begin
         smooth_ff <= avg_ff;
         near_ff   <= near_in;
         start_ff  <= start_in;
         fin_ff    <= expire;
      end
   end

   assign stat.finished = fin_ff;
   assign res           = res_ff;

endmodule

/* hw/rtl/proximity_hysteresis_hold_timer.sv */
// ----------------------------------------------------------------------------
// proximity_hysteresis_hold_timer
// Echo width to distance, exponential average, near/far hysteresis and a
// hold timer that latches done.
//
//   channel   direction  handshake           payload
//   req_ch    in         valid/ready         echo_us, now_ms
//   rsp_ch    out        valid/ready         smoothed_cm_q8, near_mode,
//                                            event_res, finished
//   csr_*     in         write enable only   csr_index, csr_wdata
//
// One item at a time: load, scale multiply, two mix multiplies and decision
// before the next acceptance; once done, only load and decision.
// The result register lets a new item be accepted while a result waits; a
// stalled result holds the decision step until the register frees.
// Synchronous reset restores register defaults and far mode.
// ----------------------------------------------------------------------------
module proximity_hysteresis_hold_timer import phht_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   phht_req_if.sink              req_ch,
   phht_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type  cfg;
   cmd_type  cmd;
   stat_type stat;
   res_type  res;

   phht_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   phht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   phht_dpath u_dpath (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .cmd     (cmd),
      .echo_us (req_ch.echo_us),
      .now_ms  (req_ch.now_ms),
      .stat    (stat),
      .res     (res)
   );

   // Drive the result channel
   assign rsp_ch.smoothed_cm_q8 = res.smoothed_cm_q8;
   assign rsp_ch.near_mode      = res.near_mode;
   assign rsp_ch.event_res      = res.event_res;
   assign rsp_ch.finished       = res.finished;

`ifndef SYNTHESIS
   // One item in flight: no acceptance on the cycle after one
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("item accepted while another is in flight");

   // Entering near mode reports near mode
   a_enter_near: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.event_res == EV_ENTER)) |-> rsp_ch.near_mode)
      else $error("enter event without near mode");

   // Returning far reports far mode
   a_return_far: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.event_res == EV_RETURN)) |-> !rsp_ch.near_mode)
      else $error("return event while still near");

   // Expiry only in near mode, and it latches done
   a_expiry: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.event_res == EV_EXPIRED))
         |-> (rsp_ch.near_mode && rsp_ch.finished))
      else $error("expiry event without near mode and done");
`endif

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the proximity hold timer. A predictor tracks the
// smoothed distance, the near/far mode, the near start time and the done
// latch, and each result item is compared field by field with the oldest
// prediction. Directed cases cover the reset values, the zero average,
// zero alpha, overlapping and extreme thresholds and masked register
// writes. Random phases follow, with threshold-seeking echoes and random
// gaps on both channels. The hold expiry comes last, since done only
// clears on reset.
// ----------------------------------------------------------------------------
module tb_top import phht_pkg::*; ;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   phht_req_if req_ch ();
   phht_rsp_if rsp_ch ();

   proximity_hysteresis_hold_timer dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor state and register copy
   cfg_type           cfg;
   logic [DIST_W-1:0] avg_q8;
   logic              near_now;
   logic [TIME_W-1:0] near_since;
   logic              hold_done;
   logic [TIME_W-1:0] ms_clock;

   res_type           expected_q[$];
   int                err_count;
   bit                req_pause_on;
   bit                rsp_pause_on;

   // Clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run limit
   initial begin
      #2_000_000;
      $display("tb_top: done, errors");
      $finish;
   end

   // Work out the result item of one accepted echo item and advance the state
   function automatic res_type predict_echo(input logic [ECHO_W-1:0] echo,
                                            input logic [TIME_W-1:0] now);
      logic [63:0]        acc;
      logic [DIST_W-1:0]  sample;
      logic [EVENT_W-1:0] ev;
      res_type            r;
      ev = EV_NONE;
      if (!hold_done) begin
         acc = (64'(echo) * 64'(cfg.speed_scale_q16) + 64'd128) >> 8;
         sample = (acc > 64'(DIST_MAX)) ? DIST_MAX : acc[DIST_W-1:0];
         if (avg_q8 == '0) begin
            avg_q8 = sample;
         end else begin
            acc = (64'(cfg.alpha_q8) * 64'(sample)
                   + (64'd256 - 64'(cfg.alpha_q8)) * 64'(avg_q8) + 64'd128) >> 8;
            avg_q8 = (acc > 64'(DIST_MAX)) ? DIST_MAX : acc[DIST_W-1:0];
         end
         // enter test first, so overlapping thresholds favour near mode
         if (32'(avg_q8) <= (32'(cfg.enter_cm) << 8)) begin
            if (!near_now) begin
               near_now   = 1'b1;
               near_since = now;
               ev         = EV_ENTER;
            end
         end else if (32'(avg_q8) >= (32'(cfg.exit_cm) << 8)) begin
            if (near_now) begin
               near_now = 1'b0;
               ev       = EV_RETURN;
            end
         end
         if (near_now && (now - near_since) >= 32'(cfg.hold_ms)) begin
            hold_done = 1'b1;
            ev        = EV_EXPIRED;
         end
      end
      r.smoothed_cm_q8 = avg_q8;
      r.near_mode      = near_now;
      r.event_res      = ev;
      r.finished       = hold_done;
      return r;
   endfunction

   // Pick a time that cannot expire the hold while in near mode
   function automatic logic [TIME_W-1:0] pick_now();
      logic [TIME_W-1:0] t;
      if (hold_done) begin
         t = $urandom();
      end else if (near_now) begin
         if ($urandom_range(0, 7) == 0)
            t = near_since + 32'(cfg.hold_ms) - 32'd1;
         else
            t = near_since + 32'($urandom_range(0, int'(cfg.hold_ms) - 1));
      end else begin
         case ($urandom_range(0, 3))
            0: ms_clock = $urandom();
            1: ms_clock = 32'hFFFF_FFFF - 32'($urandom_range(0, 400));
            default: ms_clock = ms_clock + 32'($urandom_range(0, 300));
         endcase
         t = ms_clock;
      end
      return t;
   endfunction

   // Pick an echo width, mostly near the thresholds
   function automatic logic [ECHO_W-1:0] pick_echo();
      longint top_cm;
      longint target;
      longint width;
      case ($urandom_range(0, 9))
         0: width = $urandom_range(0, 65535);
         1: width = $urandom_range(0, 1) ? 65535 : 0;
         default: begin
            top_cm = ((cfg.enter_cm > cfg.exit_cm) ? cfg.enter_cm : cfg.exit_cm) + 8;
            target = $urandom_range(0, int'(top_cm * 256));
            if (cfg.speed_scale_q16 == '0)
               width = $urandom_range(0, 65535);
            else
               width = (target * 256 + cfg.speed_scale_q16 / 2) / cfg.speed_scale_q16;
            if (width > 65535)
               width = 65535;
         end
      endcase
      return ECHO_W'(width);
   endfunction

   // Write one register; call at a falling edge while the block is idle
   task automatic write_reg(input logic [CSR_IDX_W-1:0]  idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_index = idx;
      csr_wdata = value;
      csr_we    = 1'b1;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_SPEED_SCALE: cfg.speed_scale_q16 = value[SCALE_W-1:0];
         CSR_ALPHA:       cfg.alpha_q8        = value[ALPHA_W-1:0];
         CSR_ENTER:       cfg.enter_cm        = value[THR_W-1:0];
         CSR_EXIT:        cfg.exit_cm         = value[THR_W-1:0];
         CSR_HOLD:        cfg.hold_ms         = value[HOLD_W-1:0];
         default: ;
      endcase
   endtask

   // Send one echo item; returns at the falling edge after acceptance
   task automatic send_echo(input logic [ECHO_W-1:0] echo,
                            input logic [TIME_W-1:0] now);
      int gap;
      gap = req_pause_on ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.echo_us = echo;
      req_ch.now_ms  = now;
      req_ch.valid   = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      expected_q.push_back(predict_echo(echo, now));
      @(negedge clock);
   endtask

   // Hold the sender until every predicted result item has come back
   task automatic wait_results;
      req_ch.valid = 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
   endtask

   // Receiver: draw a stall for each result item
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         stall = rsp_pause_on ? $urandom_range(0, 15) : 0;
         if (stall > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         @(negedge clock);
      end
   end

   // Compare each accepted result item with the oldest prediction
   always @(posedge clock) begin : check_results
      res_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_q.size() == 0) begin
            $error("unexpected result item: smoothed_cm_q8 %0d event_res %0d",
                   rsp_ch.smoothed_cm_q8, rsp_ch.event_res);
            err_count++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_ch.smoothed_cm_q8 !== want.smoothed_cm_q8) begin
               $error("smoothed_cm_q8: expected %0d, got %0d",
                      want.smoothed_cm_q8, rsp_ch.smoothed_cm_q8);
               err_count++;
            end
            if (rsp_ch.near_mode !== want.near_mode) begin
               $error("near_mode: expected %0d, got %0d", want.near_mode, rsp_ch.near_mode);
               err_count++;
            end
            if (rsp_ch.event_res !== want.event_res) begin
               $error("event_res: expected %0d, got %0d", want.event_res, rsp_ch.event_res);
               err_count++;
            end
            if (rsp_ch.finished !== want.finished) begin
               $error("finished: expected %0d, got %0d", want.finished, rsp_ch.finished);
               err_count++;
            end
         end
      end
   end

   // Reset values: first sample taken as it comes, enter and return far
   task automatic test_reset_values;
      send_echo(16'd500, pick_now());
      send_echo(16'hFFFF, pick_now());
      send_echo(16'd0, pick_now());
      wait_results;
   endtask

   // Masked writes and unused indexes; drive the average down to zero
   task automatic test_zero_average;
      write_reg(CSR_ALPHA, 16'hFFFF);
      write_reg(CSR_SPEED_SCALE, 16'hFFFF);
      write_reg(CSR_HOLD + 3'd1, 16'h0000);
      write_reg(CSR_HOLD + 3'd2, 16'h5A5A);
      write_reg(CSR_HOLD + 3'd3, 16'hFFFF);
      repeat (4) send_echo(16'd0, pick_now());
      send_echo(16'd1000, pick_now());
      wait_results;
   endtask

   // Zero alpha holds a non-zero average; zero scale gives zero samples
   task automatic test_zero_alpha;
      write_reg(CSR_ALPHA, 16'd0);
      send_echo(16'hFFFF, pick_now());
      send_echo(16'd12345, pick_now());
      wait_results;
      write_reg(CSR_SPEED_SCALE, 16'd0);
      send_echo(16'hFFFF, pick_now());
      wait_results;
   endtask

   // Enter threshold above exit threshold: enter test wins
   task automatic test_overlapping_thresholds;
      write_reg(CSR_SPEED_SCALE, 16'd4095);
      write_reg(CSR_ALPHA, 16'd128);
      write_reg(CSR_ENTER, 16'd1023);
      write_reg(CSR_EXIT, 16'd0);
      send_echo(16'd100, pick_now());
      send_echo(16'hFFFF, pick_now());
      send_echo(16'hFFFF, pick_now());
      wait_results;
   endtask

   // Enter at zero only, exit at the top, shortest non-zero hold
   task automatic test_threshold_extremes;
      write_reg(CSR_ALPHA, 16'd255);
      write_reg(CSR_ENTER, 16'd0);
      write_reg(CSR_EXIT, 16'd1023);
      write_reg(CSR_HOLD, 16'd1);
      repeat (4) send_echo(16'd0, pick_now());
      send_echo(16'hFFFF, pick_now());
      wait_results;
   endtask

   // One random phase: fresh register values, then random echo items
   task automatic run_random_phase(input int n_items, input bit with_pauses,
                                   input bit wrap_time);
      logic [SCALE_W-1:0] scale;
      logic [THR_W-1:0]   enter_thr;
      int                 exit_thr;
      logic [HOLD_W-1:0]  hold;
      case ($urandom_range(0, 4))
         0: scale = '1;
         1: scale = SCALE_RST;
         default: scale = SCALE_W'($urandom_range(1, 4095));
      endcase
      enter_thr = ($urandom_range(0, 3) == 0) ? THR_W'($urandom_range(0, 1023))
                                              : THR_W'($urandom_range(5, 120));
      if ($urandom_range(0, 4) == 0)
         exit_thr = $urandom_range(0, 1023);
      else
         exit_thr = enter_thr + $urandom_range(0, 40);
      if (exit_thr > 1023)
         exit_thr = 1023;
      case ($urandom_range(0, 3))
         0: hold = '1;
         1: hold = HOLD_W'($urandom_range(1, 50));
         default: hold = HOLD_W'($urandom_range(1, 65535));
      endcase
      write_reg(CSR_SPEED_SCALE, {4'($urandom()), scale});
      write_reg(CSR_ALPHA, 16'($urandom()));
      write_reg(CSR_ENTER, {6'($urandom()), enter_thr});
      write_reg(CSR_EXIT, {6'($urandom()), THR_W'(exit_thr)});
      write_reg(CSR_HOLD, hold);
      req_pause_on = with_pauses && ($urandom_range(0, 3) != 0);
      rsp_pause_on = with_pauses && ($urandom_range(0, 3) != 0);
      if (wrap_time)
         ms_clock = 32'hFFFF_FFFF - 32'd2000;
      for (int i = 0; i < n_items; i++) begin
         if ($urandom_range(0, 59) == 0)
            wait_results;
         send_echo(pick_echo(), pick_now());
      end
      wait_results;
   endtask

   task automatic test_random_traffic;
      run_random_phase(150, 1'b0, 1'b0);
      run_random_phase(150, 1'b1, 1'b0);
      run_random_phase(150, 1'b1, 1'b1);
      run_random_phase(150, 1'b1, 1'b0);
      run_random_phase(150, 1'b1, 1'b1);
      run_random_phase(150, 1'b1, 1'b0);
   endtask

   // Latch done, then check that later items are ignored
   task automatic test_hold_expiry;
      logic [TIME_W-1:0] t0;
      logic [HOLD_W-1:0] hold;
      req_pause_on = 1'b1;
      rsp_pause_on = 1'b1;
      write_reg(CSR_ALPHA, 16'd255);
      write_reg(CSR_SPEED_SCALE, 16'd4095);
      if ($urandom_range(0, 1)) begin
         // zero hold: entry and expiry fall on the same item
         write_reg(CSR_ENTER, 16'd0);
         write_reg(CSR_EXIT, 16'd0);
         send_echo(16'hFFFF, pick_now());
         wait_results;
         write_reg(CSR_HOLD, 16'd0);
         write_reg(CSR_ENTER, 16'd1023);
         send_echo(16'd0, pick_now());
      end else begin
         // timed hold: one item just short of the limit, one at it
         hold = HOLD_W'($urandom_range(1, 2000));
         write_reg(CSR_HOLD, hold);
         write_reg(CSR_ENTER, 16'd1023);
         write_reg(CSR_EXIT, 16'd1023);
         send_echo(16'd0, pick_now());
         t0 = near_since;
         send_echo(16'd0, t0 + 32'(hold) - 32'd1);
         send_echo(16'd0, t0 + 32'(hold));
      end
      repeat (3) send_echo(ECHO_W'($urandom()), $urandom());
      wait_results;
   endtask

   // Main sequence
   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      req_ch.valid   = 1'b0;
      req_ch.echo_us = '0;
      req_ch.now_ms  = '0;
      err_count      = 0;
      req_pause_on   = 1'b1;
      rsp_pause_on   = 1'b1;
      cfg            = '{SCALE_RST, ALPHA_RST, ENTER_RST, EXIT_RST, HOLD_RST};
      avg_q8         = '0;
      near_now       = 1'b0;
      near_since     = '0;
      hold_done      = 1'b0;
      ms_clock       = 32'd1000;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_values;
      test_zero_average;
      test_zero_alpha;
      test_overlapping_thresholds;
      test_threshold_extremes;
      test_random_traffic;
      test_hold_expiry;

      wait_results;
      repeat (20) @(negedge clock);
      if (err_count == 0 && expected_q.size() == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/phht_pkg.sv
hw/rtl/phht_channels.sv
hw/rtl/phht_csr.sv
hw/rtl/phht_ctrl.sv
hw/rtl/phht_dpath.sv
hw/rtl/proximity_hysteresis_hold_timer.sv
dv/tb_top.sv
